// ----- design/tcw_pkg.sv -----
// Shared types, constants and helpers of the text console writer.
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;
   localparam int CHAR_W = 8;
   localparam int CELL_W = 16;
   localparam int MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN     = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK      = 8'h20;
   localparam logic [CHAR_W-1:0] RESET_ATTRIBUTE = 8'h0F;

   localparam logic [ADDR_W-1:0] COLUMNS_A   = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] COPY_END_A  = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL_A = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] CELLS_A     = ADDR_W'(CELLS);

   // Kind of work an accepted transaction needs after its first cycle.
   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_READ   = 2'd1,
      KIND_SCROLL = 2'd2,
      KIND_CLEAR  = 2'd3
   } tcw_kind_type;

   typedef struct packed {
      logic start;        // accept the transaction, do its first-cycle work
      logic capture;      // latch the cell read data
      logic copy;         // one step of the scroll copy sweep
      logic fill;         // write one blank and advance the sweep index
      logic blank_reset;  // blanks carry the reset attribute
      logic load_result;  // load the response payload registers
   } tcw_cmd_type;

   typedef struct packed {
      tcw_kind_type kind;
      logic         copy_last;
      logic         fill_last;
   } tcw_stat_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * COLUMNS_A + ADDR_W'(col));
   endfunction

endpackage

// ----- design/tcw_datapath.sv -----
// Datapath: screen memory, cursor registers, sweep index and response payload.
module tcw_datapath import tcw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  tcw_cmd_type         cmd,
   output tcw_stat_type        stat,
   input  logic [CHAR_W-1:0]   attribute,
   input  logic [MODE_W-1:0]   mode,
   input  logic [CHAR_W-1:0]   char_code,
   input  logic [ADDR_W-1:0]   cell_index,
   output logic [ROW_W-1:0]    cursor_row,
   output logic [COL_W-1:0]    cursor_col,
   output logic [ADDR_W-1:0]   cursor_position,
   output logic [CELL_W-1:0]   cell_data,
   output logic                scrolled
);

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              scroll_ff, scroll_in;
   logic [CELL_W-1:0] data_ff, data_in;

   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ADDR_W-1:0] rsp_pos_ff;
   logic [CELL_W-1:0] rsp_data_ff;
   logic              rsp_scroll_ff;

   logic              we, re;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [CELL_W-1:0] wdata, blank;

   logic              is_put, is_newline, is_print;
   logic [COL_W:0]    col_inc;
   logic [ROW_W:0]    row_inc;
   logic              wrap, row_adv, overflow;
   logic [ADDR_W:0]   copy_src;

   assign is_put     = (mode == MODE_PUT) && (char_code != CHAR_RETURN);
   assign is_newline = char_code == CHAR_NEWLINE;
   assign is_print   = is_put && !is_newline;

   assign col_inc  = {1'b0, col_ff} + (COL_W+1)'(1);
   assign wrap     = col_inc >= (COL_W+1)'(COLUMNS);
   assign row_adv  = is_newline || wrap;
   assign row_inc  = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign overflow = row_adv && (row_inc >= (ROW_W+1)'(ROWS));

   assign copy_src = {1'b0, idx_ff} + {1'b0, COLUMNS_A};

   assign blank = cmd.blank_reset ? {RESET_ATTRIBUTE, CHAR_BLANK} : {attribute, CHAR_BLANK};

   always_comb begin
      priority if (mode == MODE_READ)       stat.kind = KIND_READ;
      else if (mode == MODE_CLEAR)          stat.kind = KIND_CLEAR;
      else if (is_put && overflow)          stat.kind = KIND_SCROLL;
      else                                  stat.kind = KIND_SIMPLE;
      stat.copy_last = idx_ff == COPY_END_A;
      stat.fill_last = idx_ff == LAST_CELL_A;
   end

   // Memory port control.
   always_comb begin
      we    = 1'b0;
      waddr = idx_ff;
      wdata = blank;
      re    = 1'b0;
      raddr = cell_index;
      if (cmd.start) begin
         we    = is_print;
         waddr = cell_addr(row_ff, col_ff);
         wdata = {attribute, char_code};
         re    = (mode == MODE_READ) && (cell_index < CELLS_A);
      end
      if (cmd.copy) begin
         re    = !stat.copy_last;
         raddr = copy_src[ADDR_W-1:0];
         we    = idx_ff != '0;
         waddr = idx_ff - ADDR_W'(1);
         wdata = rdata_ff;
      end
      if (cmd.fill) begin
         we    = 1'b1;
         waddr = idx_ff;
         wdata = blank;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Cursor, sweep index and per-transaction result state.
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      idx_in    = idx_ff;
      rd_ok_in  = rd_ok_ff;
      scroll_in = scroll_ff;
      data_in   = data_ff;
      if (cmd.start) begin
         idx_in    = '0;
         rd_ok_in  = cell_index < CELLS_A;
         scroll_in = 1'b0;
         data_in   = '0;
         if (mode == MODE_CLEAR) begin
            row_in = '0;
            col_in = '0;
         end else if (is_put) begin
            if (row_adv) begin
               col_in = '0;
            end else begin
               col_in = col_inc[COL_W-1:0];
            end
            if (overflow) begin
               row_in    = ROW_W'(ROWS - 1);
               scroll_in = 1'b1;
            end else if (row_adv) begin
               row_in = row_inc[ROW_W-1:0];
            end
         end
      end
      if (cmd.capture && rd_ok_ff) begin
         data_in = rdata_ff;
      end
      if ((cmd.copy && !stat.copy_last) || (cmd.fill && !stat.fill_last)) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         idx_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff  <= rd_ok_in;
      scroll_ff <= scroll_in;
      data_ff   <= data_in;
      if (cmd.load_result) begin
         rsp_row_ff    <= row_ff;
         rsp_col_ff    <= col_ff;
         rsp_pos_ff    <= cell_addr(row_ff, col_ff);
         rsp_data_ff   <= data_ff;
         rsp_scroll_ff <= scroll_ff;
      end
   end

   assign cursor_row      = rsp_row_ff;
   assign cursor_col      = rsp_col_ff;
   assign cursor_position = rsp_pos_ff;
   assign cell_data       = rsp_data_ff;
   assign scrolled        = rsp_scroll_ff;

endmodule

// ----- design/tcw_ctrl.sv -----
// Controller: sequences init sweep, transactions, scroll and clear sweeps, response valid.
module tcw_ctrl import tcw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  tcw_stat_type stat,
   output tcw_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_COPY  = 6'b001000,
      ST_FILL  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill        = 1'b1;
            cmd.blank_reset = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               unique case (stat.kind)
                  KIND_READ:   state_in = ST_READ;
                  KIND_SCROLL: state_in = ST_COPY;
                  KIND_CLEAR:  state_in = ST_FILL;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_READ: begin
            cmd.capture = 1'b1;
            state_in    = ST_DONE;
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (stat.copy_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- design/text_console_writer.sv -----
// Top level of the text console writer: register port, stream packing, controller and datapath.
//
//   channel  direction  bus     payload
//   req      in         stream  tdata: mode, char_code, cell_index
//   rsp      out        stream  tdata: cursor_row, cursor_col, cursor_position,
//                               cell_data, scrolled
//   csr      in/out     APB     attribute at byte address 0
//
// A put, carriage return or unused mode goes from idle straight to done, a read passes
// the capture state first; a put that scrolls makes 1921 copy steps through the one read /
// one write screen memory, then 80 blank writes; a clear makes one blank write per cell.
// After reset the block blanks all 2000 cells, one per cycle, and takes no transaction
// until that sweep ends; csr writes are taken throughout.
// A finished response waits in the output register; the next transaction is accepted
// meanwhile and only its completion stalls while rsp_tready stays low.
module text_console_writer import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // req_tdata, from bit 0: mode[1:0], char_code[9:2], cell_index[20:10], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // rsp_tdata, from bit 0: cursor_row[4:0], cursor_col[11:5], cursor_position[22:12],
   // cell_data[38:23], scrolled[39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tcw_cmd_type       cmd;
   tcw_stat_type      stat;
   logic [CHAR_W-1:0] attribute_ff, attribute_in;
   logic              attr_sel;

   logic [ROW_W-1:0]  cursor_row;
   logic [COL_W-1:0]  cursor_col;
   logic [ADDR_W-1:0] cursor_position;
   logic [CELL_W-1:0] cell_data;
   logic              scrolled;

   // Register index is paddr[2]; only index 0 exists.
   assign attr_sel   = !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = attr_sel ? {24'd0, attribute_ff} : 32'd0;

   always_comb begin
      attribute_in = attribute_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && attr_sel) begin
         attribute_in = csr_pwdata[CHAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_ff <= RESET_ATTRIBUTE;
      end else begin
         attribute_ff <= attribute_in;
      end
   end

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .attribute       (attribute_ff),
      .mode            (req_tdata[1:0]),
      .char_code       (req_tdata[9:2]),
      .cell_index      (req_tdata[20:10]),
      .cursor_row      (cursor_row),
      .cursor_col      (cursor_col),
      .cursor_position (cursor_position),
      .cell_data       (cell_data),
      .scrolled        (scrolled)
   );

   // Pack the response transaction, first field lowest.
   assign rsp_tdata = {scrolled, cell_data, cursor_position, cursor_col, cursor_row};

endmodule
